// ===== rtl/uart_line_assembler_assert.svh =====
// assertion macros for the line assembler checks
// used by the port checker; expects clk and rst_n in the enclosing scope
`ifndef UART_LINE_ASSEMBLER_ASSERT_SVH
`define UART_LINE_ASSEMBLER_ASSERT_SVH

// same-cycle implication
`define ULA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line assembler check failed");

// next-cycle implication
`define ULA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line assembler check failed");

`endif

// ===== rtl/ula_pkg.sv =====
// shared types and constants for the uart line assembler
// no dependencies
package ula_pkg;

    localparam int unsigned LINE_DEPTH_DEF = 16;

    localparam logic [7:0] TERMINATOR_RST = 8'h0D;
    localparam logic [4:0] LINE_LIMIT_RST = 5'd16;
    localparam logic [7:0] PRINT_LO       = 8'h20;
    localparam logic [7:0] PRINT_HI       = 8'h7E;

    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 32;

    typedef enum logic {
        REG_TERMINATOR = 1'b0,
        REG_LINE_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_BREAK   = 3'd1,
        ST_FAULT   = 3'd2,
        ST_CHAR    = 3'd3,
        ST_DROPPED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_SINGLE,
        K_EMIT
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_START,
        S_EMIT,
        S_TERM
    } state_t;

    typedef struct packed {
        logic item_load;
        logic eval_commit;
        logic rd_start;
        logic emit_char;
        logic emit_term;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  fill_empty;
        logic  emit_done;
    } sts_t;

endpackage

// ===== rtl/ula_rx_if.sv =====
// receive item channel: byte, break and fault flags, or a release item
// depends on nothing
interface ula_rx_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;
    logic       break_seen;
    logic       rx_fault;

    modport source (output valid, func, rx_byte, break_seen, rx_fault, input ready);
    modport sink   (input valid, func, rx_byte, break_seen, rx_fault, output ready);
endinterface

// ===== rtl/ula_line_if.sv =====
// result channel: status, line character and last flag
// depends on ula_pkg
interface ula_line_if;
    logic              valid;
    logic              ready;
    ula_pkg::status_t  status;
    logic [7:0]        line_char;
    logic              last;

    modport source (output valid, status, line_char, last, input ready);
    modport sink   (input valid, status, line_char, last, output ready);
endinterface

// ===== rtl/ula_ctrl.sv =====
// controller state machine for the line assembler
// depends on ula_pkg; drives commands to ula_datapath
module ula_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rx_valid,
    output logic            rx_ready,
    input  ula_pkg::sts_t   sts,
    output ula_pkg::cmd_t   cmd
);

    ula_pkg::state_t state_reg;
    ula_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ula_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ula_pkg::S_IDLE:
            begin
                if (rx_valid)
                begin
                    state_next = ula_pkg::S_EVAL;
                end
            end
            ula_pkg::S_EVAL:
            begin
                if (sts.out_free)
                begin
                    state_next = (sts.kind == ula_pkg::K_EMIT) ? ula_pkg::S_START
                                                               : ula_pkg::S_IDLE;
                end
            end
            ula_pkg::S_START:
            begin
                state_next = sts.fill_empty ? ula_pkg::S_TERM : ula_pkg::S_EMIT;
            end
            ula_pkg::S_EMIT:
            begin
                if (sts.out_free && sts.emit_done)
                begin
                    state_next = ula_pkg::S_TERM;
                end
            end
            ula_pkg::S_TERM:
            begin
                if (sts.out_free)
                begin
                    state_next = ula_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ula_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rx_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ula_pkg::S_IDLE:
            begin
                rx_ready      = 1'b1;
                cmd.item_load = rx_valid;
            end
            ula_pkg::S_EVAL:
            begin
                cmd.eval_commit = sts.out_free;
            end
            ula_pkg::S_START:
            begin
                cmd.rd_start = 1'b1;
            end
            ula_pkg::S_EMIT:
            begin
                cmd.emit_char = sts.out_free;
            end
            ula_pkg::S_TERM:
            begin
                cmd.emit_term = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ula_datapath.sv =====
// datapath: item register, line store, fill count, result register
// depends on ula_pkg; steered by ula_ctrl
module ula_datapath #(
    parameter int unsigned LINE_DEPTH = ula_pkg::LINE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ula_pkg::cmd_t     cmd,
    output ula_pkg::sts_t     sts,
    input  logic [7:0]        terminator,
    input  logic [4:0]        line_limit,
    input  logic              func,
    input  logic [7:0]        rx_byte,
    input  logic              break_seen,
    input  logic              rx_fault,
    output logic              line_valid,
    input  logic              line_ready,
    output ula_pkg::status_t  status,
    output logic [7:0]        line_char,
    output logic              last
);

    localparam int unsigned IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(LINE_DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // item register
    logic       func_reg;
    logic [7:0] byte_reg;
    logic       brk_reg;
    logic       fault_reg;

    // line state
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             rx_en_reg;
    logic             rx_en_next;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       line_store [LINE_DEPTH];
    logic [7:0]       rd_data_reg;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    ula_pkg::status_t status_reg;
    logic [7:0]       char_reg;
    logic             last_reg;

    logic [CMP_W-1:0] lim;
    logic             printable;
    logic             is_term;
    logic             can_store;
    logic [CNT_W-1:0] fill_inc;
    logic             complete;
    logic             do_store;
    ula_pkg::kind_t   kind;
    ula_pkg::status_t single_st;
    logic [CNT_W-1:0] idx_plus;
    logic             emit_done;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_free;
    logic             load_out;

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            func_reg  <= func;
            byte_reg  <= rx_byte;
            brk_reg   <= break_seen;
            fault_reg <= rx_fault;
        end
    end

    // effective limit, clamped to 1..LINE_DEPTH
    always_comb
    begin
        lim = CMP_W'(line_limit);
        if (lim == '0)
        begin
            lim = CMP_W'(1);
        end
        if (lim > CMP_W'(LINE_DEPTH))
        begin
            lim = CMP_W'(LINE_DEPTH);
        end
    end

    assign printable = (byte_reg >= ula_pkg::PRINT_LO) && (byte_reg <= ula_pkg::PRINT_HI);
    assign is_term   = (byte_reg == terminator);
    assign can_store = (fill_reg != CNT_W'(LINE_DEPTH));
    assign fill_inc  = fill_reg + CNT_W'(can_store);
    assign complete  = (CMP_W'(fill_inc) >= lim);

    always_comb
    begin
        kind      = ula_pkg::K_NONE;
        single_st = ula_pkg::ST_NONE;
        do_store  = 1'b0;
        if (func_reg)
        begin
            kind = ula_pkg::K_NONE;
        end
        else if (!rx_en_reg)
        begin
            kind      = ula_pkg::K_SINGLE;
            single_st = ula_pkg::ST_DROPPED;
        end
        else if (brk_reg)
        begin
            kind      = ula_pkg::K_SINGLE;
            single_st = ula_pkg::ST_BREAK;
        end
        else if (fault_reg)
        begin
            kind      = ula_pkg::K_SINGLE;
            single_st = ula_pkg::ST_FAULT;
        end
        else if (is_term)
        begin
            kind = ula_pkg::K_EMIT;
        end
        else if (printable)
        begin
            do_store = can_store;
            kind     = complete ? ula_pkg::K_EMIT : ula_pkg::K_NONE;
        end
    end

    always_comb
    begin
        fill_next  = fill_reg;
        rx_en_next = rx_en_reg;
        if (cmd.eval_commit)
        begin
            if (func_reg)
            begin
                rx_en_next = 1'b1;
            end
            else if (rx_en_reg && brk_reg)
            begin
                fill_next = '0;
            end
            else if (do_store)
            begin
                fill_next = fill_inc;
            end
        end
        if (cmd.emit_term)
        begin
            fill_next  = '0;
            rx_en_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rx_en_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rx_en_reg     <= rx_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.eval_commit && do_store)
        begin
            line_store[fill_reg[IDX_W-1:0]] <= byte_reg;
        end
    end

    assign idx_plus  = CNT_W'(idx_reg) + CNT_W'(1);
    assign emit_done = (idx_plus == fill_reg);
    assign rd_en     = cmd.rd_start || (cmd.emit_char && !emit_done);
    assign rd_addr   = cmd.rd_start ? '0 : idx_plus[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            idx_reg     <= rd_addr;
            rd_data_reg <= line_store[rd_addr];
        end
    end

    // result register
    assign out_free = !out_valid_reg || line_ready;
    assign load_out = (cmd.eval_commit && (kind == ula_pkg::K_SINGLE))
                      || cmd.emit_char || cmd.emit_term;

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (line_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_char)
        begin
            status_reg <= ula_pkg::ST_CHAR;
            char_reg   <= rd_data_reg;
            last_reg   <= 1'b0;
        end
        else if (cmd.emit_term)
        begin
            status_reg <= ula_pkg::ST_CHAR;
            char_reg   <= 8'h00;
            last_reg   <= 1'b1;
        end
        else if (load_out)
        begin
            status_reg <= single_st;
            char_reg   <= 8'h00;
            last_reg   <= 1'b1;
        end
    end

    assign sts.kind       = kind;
    assign sts.out_free   = out_free;
    assign sts.fill_empty = (fill_reg == '0);
    assign sts.emit_done  = emit_done;

    assign line_valid = out_valid_reg;
    assign status     = status_reg;
    assign line_char  = char_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/uart_line_assembler.sv =====
// top level of the uart line assembler: config registers, controller, datapath
// depends on ula_pkg, ula_rx_if, ula_line_if, ula_ctrl, ula_datapath
//
//   channel   kind       beat contents
//   rx        sink       func, rx_byte, break_seen, rx_fault
//   lines     source     status, line_char, last
//   apb       cfg slave  terminator at 0x0, line_limit at 0x4
//
// an item is accepted (S_IDLE), then evaluated (S_EVAL) once its result slot is free
// a completed line of n characters is read out through S_START, S_EMIT and S_TERM,
// one beat per cycle while the result slot is free, paced by the single read port of the line store
// reset is immediate: no clearing pass, only written entries of the line store are emitted
// a stalled result holds the controller; rx takes at most one more beat, then stays low
// until the result drains
module uart_line_assembler #(
    parameter int unsigned LINE_DEPTH = ula_pkg::LINE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ula_rx_if.sink                     rx,
    ula_line_if.source                 lines,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ula_pkg::CFG_AW-1:0] paddr,
    input  logic [ula_pkg::CFG_DW-1:0] pwdata,
    output logic [ula_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    logic [7:0]        terminator_reg;
    logic [4:0]        line_limit_reg;
    ula_pkg::reg_idx_t reg_idx;
    logic              cfg_wr;

    ula_pkg::cmd_t     cmd;
    ula_pkg::sts_t     sts;
    logic              rx_ready;
    logic              line_valid;
    ula_pkg::status_t  line_status;
    logic [7:0]        line_char;
    logic              line_last;

    assign pready  = 1'b1;
    assign reg_idx = ula_pkg::reg_idx_t'(paddr[ula_pkg::CFG_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminator_reg <= ula_pkg::TERMINATOR_RST;
            line_limit_reg <= ula_pkg::LINE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ula_pkg::REG_TERMINATOR: terminator_reg <= pwdata[7:0];
                ula_pkg::REG_LINE_LIMIT: line_limit_reg <= pwdata[4:0];
                default:                 terminator_reg <= terminator_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ula_pkg::REG_TERMINATOR: prdata = {24'h000000, terminator_reg};
            ula_pkg::REG_LINE_LIMIT: prdata = {27'h0000000, line_limit_reg};
            default:                 prdata = '0;
        endcase
    end

    ula_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ula_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .terminator (terminator_reg),
        .line_limit (line_limit_reg),
        .func       (rx.func),
        .rx_byte    (rx.rx_byte),
        .break_seen (rx.break_seen),
        .rx_fault   (rx.rx_fault),
        .line_valid (line_valid),
        .line_ready (lines.ready),
        .status     (line_status),
        .line_char  (line_char),
        .last       (line_last)
    );

    assign rx.ready        = rx_ready;
    assign lines.valid     = line_valid;
    assign lines.status    = line_status;
    assign lines.line_char = line_char;
    assign lines.last      = line_last;

endmodule

// ===== rtl/ula_checker.sv =====
// port-level checks for the uart line assembler, bound to the top level
// depends on ula_pkg and uart_line_assembler_assert.svh
`include "uart_line_assembler_assert.svh"

module ula_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             rx_ready,
    input logic             line_valid,
    input logic             line_ready,
    input ula_pkg::status_t line_status,
    input logic [7:0]       line_char,
    input logic             line_last
);

    `ULA_ASSERT_NEXT(a_line_hold, line_valid && !line_ready, line_valid && $stable(line_status) && $stable(line_char) && $stable(line_last))
    `ULA_ASSERT_SAME(a_status_set, line_valid, line_status != ula_pkg::ST_NONE)
    `ULA_ASSERT_SAME(a_single_last, line_valid && line_status != ula_pkg::ST_CHAR, line_last && line_char == 8'h00)
    `ULA_ASSERT_SAME(a_busy_in_line, line_valid && line_status == ula_pkg::ST_CHAR && !line_last, !rx_ready)

endmodule

bind uart_line_assembler ula_checker u_ula_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_ready    (rx.ready),
    .line_valid  (lines.valid),
    .line_ready  (lines.ready),
    .line_status (lines.status),
    .line_char   (lines.line_char),
    .line_last   (lines.last)
);

// ===== tb/tb.sv =====
// testbench for uart_line_assembler: drives receive items and apb register writes
// and checks every result beat against an in-bench model of the line store
// depends on ula_pkg, ula_rx_if, ula_line_if and the uart_line_assembler rtl
`timescale 1ns / 100ps

module tb;
    import ula_pkg::*;

    localparam int unsigned LINE_DEPTH     = LINE_DEPTH_DEF;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       break_seen;
        logic       rx_fault;
    } rx_item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] line_char;
        logic       last;
    } line_beat_t;

    class line_scoreboard;
        logic [7:0]  term_char;
        logic [4:0]  limit_reg;
        logic [7:0]  line_buf [LINE_DEPTH];
        int unsigned line_len;
        bit          rx_on;
        line_beat_t  expected_beats [$];
        int unsigned errors;

        function new();
            term_char = TERMINATOR_RST;
            limit_reg = LINE_LIMIT_RST;
            line_len  = 0;
            rx_on     = 1'b1;
            errors    = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_TERMINATOR: term_char = value[7:0];
                REG_LINE_LIMIT: limit_reg = value[4:0];
                default: ;
            endcase
        endfunction

        function void push_beat(status_t st, logic [7:0] ch, logic lst);
            line_beat_t b;
            b.status    = st;
            b.line_char = ch;
            b.last      = lst;
            expected_beats.push_back(b);
        endfunction

        function void flush_line();
            for (int i = 0; i < line_len; i++)
                push_beat(ST_CHAR, line_buf[i], 1'b0);
            push_beat(ST_CHAR, 8'h00, 1'b1);
            line_len = 0;
            rx_on    = 1'b0;
        endfunction

        function void note_rx(rx_item_t it);
            int unsigned lim;
            lim = (limit_reg == 0) ? 1 : ((limit_reg > LINE_DEPTH) ? LINE_DEPTH : limit_reg);
            if (it.func)
                rx_on = 1'b1;
            else if (!rx_on)
                push_beat(ST_DROPPED, 8'h00, 1'b1);
            else if (it.break_seen)
            begin
                line_len = 0;
                push_beat(ST_BREAK, 8'h00, 1'b1);
            end
            else if (it.rx_fault)
                push_beat(ST_FAULT, 8'h00, 1'b1);
            else if (it.rx_byte == term_char)
                flush_line();
            else if (it.rx_byte >= PRINT_LO && it.rx_byte <= PRINT_HI)
            begin
                if (line_len < LINE_DEPTH)
                begin
                    line_buf[line_len] = it.rx_byte;
                    line_len++;
                end
                if (line_len >= lim)
                    flush_line();
            end
        endfunction

        function void check_beat(status_t st, logic [7:0] ch, logic lst);
            line_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: status %0d line_char 0x%02h last %0b", st, ch, lst);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (st !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, st);
                    errors++;
                end
                if (ch !== want.line_char)
                begin
                    $error("line_char: expected 0x%02h, got 0x%02h", want.line_char, ch);
                    errors++;
                end
                if (lst !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, lst);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    int unsigned         tx_idle_pct;
    int unsigned         rx_idle_pct;
    int unsigned         quiet_cycles;
    line_scoreboard      sb;

    ula_rx_if   rx ();
    ula_line_if lines ();

    uart_line_assembler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .lines   (lines),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        lines.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && lines.valid && lines.ready)
            sb.check_beat(lines.status, lines.line_char, lines.last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx.valid && rx.ready) || (lines.valid && lines.ready) || (psel && penable))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("uart_line_assembler: mismatch");
                $finish;
            end
        end
    end

    function automatic rx_item_t mk(logic f, logic [7:0] b, logic brk, logic flt);
        rx_item_t it;
        it.func       = f;
        it.rx_byte    = b;
        it.break_seen = brk;
        it.rx_fault   = flt;
        return it;
    endfunction

    // mostly printable bytes and terminators, some breaks and faults, a release mostly once a line is out
    function automatic rx_item_t next_item(int unsigned term_pct);
        rx_item_t    it;
        int unsigned pick;
        it = mk(1'b0, 8'($urandom()), 1'b0, 1'b0);
        pick = $urandom_range(99);
        if ((!sb.rx_on && pick < 80) || pick < 5)
            it = mk(1'b1, it.rx_byte, 1'($urandom()), 1'($urandom()));
        else if (pick < 9)
        begin
            it.break_seen = 1'b1;
            it.rx_fault   = 1'($urandom());
        end
        else if (pick < 14)
            it.rx_fault = 1'b1;
        else if (pick < 14 + term_pct)
            it.rx_byte = sb.term_char;
        else if (pick < 90)
            it.rx_byte = 8'($urandom_range(PRINT_LO, PRINT_HI));
        return it;
    endfunction

    task automatic send_item(input rx_item_t it);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        rx.valid      <= 1'b1;
        rx.func       <= it.func;
        rx.rx_byte    <= it.rx_byte;
        rx.break_seen <= it.break_seen;
        rx.rx_fault   <= it.rx_fault;
        do @(posedge clk); while (!rx.ready);
        sb.note_rx(it);
    endtask

    task automatic settle();
        rx.valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic run_segment(input logic [7:0] term, input logic [4:0] limit,
                               input int unsigned tx_pct, input int unsigned rx_pct,
                               input int unsigned n, input int unsigned term_pct);
        settle();
        write_reg(REG_TERMINATOR, {24'($urandom()), term});
        write_reg(REG_LINE_LIMIT, {27'($urandom()), limit});
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) send_item(next_item(term_pct));
    endtask

    initial
    begin
        sb            = new();
        tx_idle_pct   = 17;
        rx_idle_pct   = 83;
        rst_n         <= 1'b0;
        rx.valid      <= 1'b0;
        rx.func       <= 1'b0;
        rx.rx_byte    <= 8'h00;
        rx.break_seen <= 1'b0;
        rx.rx_fault   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: terminator carriage return, limit 16
        send_item(mk(1'b0, 8'h20, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h7E, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h1F, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h7F, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'hFF, 1'b0, 1'b1));
        send_item(mk(1'b0, 8'h0D, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h00, 1'b1, 1'b0));
        send_item(mk(1'b0, 8'hFF, 1'b1, 1'b1));
        send_item(mk(1'b1, 8'hFF, 1'b1, 1'b1));
        send_item(mk(1'b0, 8'h42, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h55, 1'b1, 1'b1));
        send_item(mk(1'b0, 8'h0D, 1'b0, 1'b0));
        send_item(mk(1'b1, 8'h00, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h30, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h0D, 1'b0, 1'b1));
        send_item(mk(1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(1'b0, 8'h0D, 1'b0, 1'b0));
        send_item(mk(1'b1, 8'hA5, 1'b0, 1'b1));

        run_segment(8'h0D, 5'd16, 17, 83, 35, 6);
        run_segment(8'h41, 5'd0,  17, 83, 30, 8);
        run_segment(8'h00, 5'd31, 83, 17, 35, 2);
        run_segment(8'hFF, 5'd1,  83, 17, 30, 5);
        run_segment(8'h0A, 5'd5,  0,  0,  35, 10);
        run_segment(8'h7E, 5'd17, 0,  0,  35, 2);

        settle();
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("uart_line_assembler: match");
        else
            $display("uart_line_assembler: mismatch");
        $finish;
    end
endmodule
